// ===== hw/rtl/fsrr_pkg.sv =====
// shared constants, codes and types of the fec symbol round-robin scheduler
`default_nettype none
package fsrr_pkg;

    localparam int MAX_SLOTS    = 8;
    localparam int SLOT_W       = 3;
    localparam int NSLOT_W      = 4;
    localparam int COUNT_W      = 16;
    localparam int IDX_W        = 16;
    localparam int ID_W         = 48;
    localparam int SPACE_W      = 20;
    localparam int NEED_W       = 18;
    localparam int HDR_PER_SLOT = 4;
    localparam int QUEUE_DEPTH  = 2;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_SYMBOLS  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENCODED_SYMBOLS = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYMBOL_BYTES    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEADER_BYTES    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_SLOTS    = 3'd4;

    localparam logic signed [3:0] STREAM_NONE = -4'sd1;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    typedef struct packed {
        logic [15:0]        source_symbols;
        logic [15:0]        encoded_symbols;
        logic [15:0]        symbol_bytes;
        logic [7:0]         header_bytes;
        logic [NSLOT_W-1:0] n_slots;
    } cfg_t;

    // one scheduled tick, waiting for the result stage
    typedef struct packed {
        logic                                 sent;
        logic                                 repair;
        logic [ID_W-1:0]                      id;
        logic signed [3:0]                    stream;
        logic [NSLOT_W-1:0]                   nres;
        logic [MAX_SLOTS-1:0][COUNT_W-1:0]    counts;
    } job_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fec_symbol_round_robin_scheduler.sv =====
// top level of the fec symbol round-robin scheduler: config registers and stage wiring
`default_nettype none
// Each accepted input item is one send tick. The front end checks the free
// transmit space, picks the next ready slot round robin (or a repair symbol
// once the block's source symbols are out) and updates the index, block base
// and per-slot counts in the cycle it takes the item; it takes a new item
// every cycle while its two-entry job queue has room. The result stage then
// emits one result per cycle unless m_ready stalls it: one per active slot
// (1 to 8) for a sent symbol, a single result when the tick is skipped.
// Configuration writes are accepted at any time and should be made while idle.
module fec_symbol_round_robin_scheduler (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [fsrr_pkg::SPACE_W-1:0]    s_tx_space,
    input  wire logic [fsrr_pkg::MAX_SLOTS-1:0]  s_ready_mask,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_sent,
    output logic                                 m_is_repair,
    output logic [fsrr_pkg::ID_W-1:0]            m_symbol_id,
    output logic signed [3:0]                    m_stream_slot,
    output logic [fsrr_pkg::SLOT_W-1:0]          m_slot_index,
    output logic [fsrr_pkg::COUNT_W-1:0]         m_slot_count,
    output logic                                 m_last,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [fsrr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [fsrr_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [15:0]                  source_symbols_reg;
    logic [15:0]                  encoded_symbols_reg;
    logic [15:0]                  symbol_bytes_reg;
    logic [7:0]                   header_bytes_reg;
    logic [fsrr_pkg::NSLOT_W-1:0] active_slots_reg;

    fsrr_pkg::cfg_t cfg;
    fsrr_pkg::job_t job;
    fsrr_pkg::job_t head;
    logic           push;
    logic           pop;
    logic           full;
    logic           head_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_symbols_reg  <= 16'd100;
            encoded_symbols_reg <= 16'd120;
            symbol_bytes_reg    <= 16'd1024;
            header_bytes_reg    <= 8'd16;
            active_slots_reg    <= fsrr_pkg::NSLOT_W'(1);
        end else if (cfg_valid) begin
            case (cfg_addr)
                fsrr_pkg::CFG_SOURCE_SYMBOLS:  source_symbols_reg  <= cfg_data[15:0];
                fsrr_pkg::CFG_ENCODED_SYMBOLS: encoded_symbols_reg <= cfg_data[15:0];
                fsrr_pkg::CFG_SYMBOL_BYTES:    symbol_bytes_reg    <= cfg_data[15:0];
                fsrr_pkg::CFG_HEADER_BYTES:    header_bytes_reg    <= cfg_data[7:0];
                fsrr_pkg::CFG_ACTIVE_SLOTS:
                    active_slots_reg <= cfg_data[fsrr_pkg::NSLOT_W-1:0];
                default: ;
            endcase
        end
    end

    // zero active slots acts as one, too many as the maximum
    always_comb begin
        cfg.source_symbols  = source_symbols_reg;
        cfg.encoded_symbols = encoded_symbols_reg;
        cfg.symbol_bytes    = symbol_bytes_reg;
        cfg.header_bytes    = header_bytes_reg;
        if (active_slots_reg == '0) begin
            cfg.n_slots = fsrr_pkg::NSLOT_W'(1);
        end else if (active_slots_reg > fsrr_pkg::NSLOT_W'(fsrr_pkg::MAX_SLOTS)) begin
            cfg.n_slots = fsrr_pkg::NSLOT_W'(fsrr_pkg::MAX_SLOTS);
        end else begin
            cfg.n_slots = active_slots_reg;
        end
    end

    assign s_ready = !full;

    fsrr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .tx_space   (s_tx_space),
        .ready_mask (s_ready_mask),
        .job        (job),
        .push       (push)
    );

    fsrr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .job_in     (job),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    fsrr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sent        (m_sent),
        .m_is_repair   (m_is_repair),
        .m_symbol_id   (m_symbol_id),
        .m_stream_slot (m_stream_slot),
        .m_slot_index  (m_slot_index),
        .m_slot_count  (m_slot_count),
        .m_last        (m_last)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/fsrr_front.sv =====
// front end: space check, round-robin slot search and block bookkeeping
`default_nettype none
module fsrr_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire fsrr_pkg::cfg_t                cfg,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [fsrr_pkg::SPACE_W-1:0]  tx_space,
    input  wire logic [fsrr_pkg::MAX_SLOTS-1:0] ready_mask,
    output fsrr_pkg::job_t                     job,
    output logic                               push
);

    logic [fsrr_pkg::IDX_W-1:0]   idx_reg;
    logic [fsrr_pkg::ID_W-1:0]    base_reg;
    logic [fsrr_pkg::SLOT_W-1:0]  ptr_reg;
    logic [fsrr_pkg::MAX_SLOTS-1:0][fsrr_pkg::COUNT_W-1:0] counts_reg;

    logic [fsrr_pkg::NEED_W-1:0]  need;
    logic                         space_ok;
    logic                         in_source;
    logic [fsrr_pkg::SLOT_W-1:0]  p_norm;
    logic                         found;
    logic [fsrr_pkg::SLOT_W-1:0]  sel;
    logic [fsrr_pkg::NSLOT_W-1:0] cand_sum;
    logic [fsrr_pkg::NSLOT_W-1:0] cand;
    logic [fsrr_pkg::NSLOT_W-1:0] sel_inc;
    logic [fsrr_pkg::SLOT_W-1:0]  ptr_after;
    logic                         emit;
    logic                         take_src;
    logic [fsrr_pkg::IDX_W:0]     idx_inc;
    logic                         wrap;
    logic [fsrr_pkg::MAX_SLOTS-1:0][fsrr_pkg::COUNT_W-1:0] counts_inc;

    assign push = in_valid && in_ready;

    always_comb begin
        need = fsrr_pkg::NEED_W'(cfg.symbol_bytes) + fsrr_pkg::NEED_W'(cfg.header_bytes)
             + fsrr_pkg::NEED_W'(cfg.n_slots) * fsrr_pkg::NEED_W'(fsrr_pkg::HDR_PER_SLOT);
        space_ok  = tx_space >= fsrr_pkg::SPACE_W'(need);
        in_source = idx_reg < cfg.source_symbols;
        p_norm    = ({1'b0, ptr_reg} >= cfg.n_slots) ? '0 : ptr_reg;
    end

    // first ready slot at or after the pointer, wrapping within the active slots
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int j = fsrr_pkg::MAX_SLOTS - 1; j >= 0; j--) begin
            cand_sum = fsrr_pkg::NSLOT_W'({1'b0, p_norm}) + fsrr_pkg::NSLOT_W'(j);
            cand     = (cand_sum >= cfg.n_slots) ? cand_sum - cfg.n_slots : cand_sum;
            if (fsrr_pkg::NSLOT_W'(j) < cfg.n_slots
                    && ready_mask[cand[fsrr_pkg::SLOT_W-1:0]]) begin
                found = 1'b1;
                sel   = cand[fsrr_pkg::SLOT_W-1:0];
            end
        end
        sel_inc   = fsrr_pkg::NSLOT_W'(sel) + fsrr_pkg::NSLOT_W'(1);
        ptr_after = (sel_inc == cfg.n_slots) ? '0 : sel_inc[fsrr_pkg::SLOT_W-1:0];
    end

    always_comb begin
        take_src = space_ok && in_source && found;
        emit     = space_ok && (!in_source || found);
        idx_inc  = {1'b0, idx_reg} + (fsrr_pkg::IDX_W+1)'(1);
        wrap     = idx_inc[fsrr_pkg::IDX_W]
                || (idx_inc[fsrr_pkg::IDX_W-1:0] >= cfg.encoded_symbols);
        for (int i = 0; i < fsrr_pkg::MAX_SLOTS; i++) begin
            counts_inc[i] = counts_reg[i];
            if (take_src && sel == fsrr_pkg::SLOT_W'(i)
                    && counts_reg[i] != fsrr_pkg::COUNT_MAX) begin
                counts_inc[i] = counts_reg[i] + fsrr_pkg::COUNT_W'(1);
            end
        end
    end

    always_comb begin
        job.sent   = emit;
        job.repair = emit && !in_source;
        job.id     = emit ? base_reg + fsrr_pkg::ID_W'(idx_reg) : '0;
        job.stream = take_src ? $signed({1'b0, sel}) : fsrr_pkg::STREAM_NONE;
        job.nres   = emit ? cfg.n_slots : fsrr_pkg::NSLOT_W'(1);
        job.counts = emit ? counts_inc : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            base_reg   <= '0;
            ptr_reg    <= '0;
            counts_reg <= '0;
        end else if (push) begin
            if (space_ok && in_source) begin
                ptr_reg <= found ? ptr_after : p_norm;
            end
            if (emit) begin
                if (wrap) begin
                    idx_reg    <= '0;
                    base_reg   <= base_reg + fsrr_pkg::ID_W'(cfg.encoded_symbols);
                    counts_reg <= '0;
                end else begin
                    idx_reg    <= idx_inc[fsrr_pkg::IDX_W-1:0];
                    counts_reg <= counts_inc;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_skip_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !space_ok) |=> ($stable(idx_reg) && $stable(ptr_reg) && $stable(base_reg)))
        else $error("skipped tick changed scheduler state");
    a_emit_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && emit && !wrap) |=> (idx_reg == $past(idx_reg) + fsrr_pkg::IDX_W'(1)))
        else $error("symbol index did not advance after a symbol");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/fsrr_queue.sv =====
// short job queue between the scheduling front end and the result stage
`default_nettype none
module fsrr_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire fsrr_pkg::job_t job_in,
    output logic                full,
    input  wire logic           pop,
    output fsrr_pkg::job_t      head,
    output logic                head_valid
);

    localparam int PTR_W = (fsrr_pkg::QUEUE_DEPTH > 1) ? $clog2(fsrr_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(fsrr_pkg::QUEUE_DEPTH + 1);

    fsrr_pkg::job_t     entry_reg [fsrr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full       = count_reg == CNT_W'(fsrr_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(fsrr_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(fsrr_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("job queue popped while empty");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("job queue written while full");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/fsrr_back.sv =====
// result stage: walks the per-slot counts of one job, one result per cycle unless stalled by m_ready
`default_nettype none
module fsrr_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire fsrr_pkg::job_t               head,
    input  wire logic                         head_valid,
    output logic                              pop,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_sent,
    output logic                              m_is_repair,
    output logic [fsrr_pkg::ID_W-1:0]         m_symbol_id,
    output logic signed [3:0]                 m_stream_slot,
    output logic [fsrr_pkg::SLOT_W-1:0]       m_slot_index,
    output logic [fsrr_pkg::COUNT_W-1:0]      m_slot_count,
    output logic                              m_last
);

    logic [fsrr_pkg::SLOT_W-1:0]  k_reg;
    logic                         m_valid_reg;
    logic                         sent_reg;
    logic                         repair_reg;
    logic [fsrr_pkg::ID_W-1:0]    id_reg;
    logic signed [3:0]            stream_reg;
    logic [fsrr_pkg::SLOT_W-1:0]  index_reg;
    logic [fsrr_pkg::COUNT_W-1:0] count_reg;
    logic                         last_reg;

    logic load;
    logic last_item;

    assign load      = head_valid && (!m_valid_reg || m_ready);
    assign last_item = (fsrr_pkg::NSLOT_W'(k_reg) + fsrr_pkg::NSLOT_W'(1)) == head.nres;
    assign pop       = load && last_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                k_reg       <= last_item ? '0 : k_reg + fsrr_pkg::SLOT_W'(1);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sent_reg   <= head.sent;
            repair_reg <= head.repair;
            id_reg     <= head.id;
            stream_reg <= head.stream;
            index_reg  <= k_reg;
            count_reg  <= head.counts[k_reg];
            last_reg   <= last_item;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sent        = sent_reg;
    assign m_is_repair   = repair_reg;
    assign m_symbol_id   = id_reg;
    assign m_stream_slot = stream_reg;
    assign m_slot_index  = index_reg;
    assign m_slot_count  = count_reg;
    assign m_last        = last_reg;

`ifndef SYNTHESIS
    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> (fsrr_pkg::NSLOT_W'(k_reg) < head.nres))
        else $error("result walk ran past the job's slot count");
    a_restart_after_job: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (k_reg == '0 && m_last))
        else $error("result walk did not close the job");
`endif

endmodule
`default_nettype wire
